[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every clock edge outside reset
`define BED_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// check that a condition implies another in the same cycle
`define BED_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  `BED_ASSERT(lbl, clk, rst, (ante) |-> (cons), msg)

`endif

[rtl/bed_pkg.sv]
package bed_pkg;

  localparam int BED_QUEUE_DEPTH = 4;

  localparam logic [31:0] CP_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] CP_ASCII   = 32'h0000_007F;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;

  localparam logic [3:0] OCT_DIGITS      = 4'd3;
  localparam logic [3:0] OCT_LONG_DIGITS = 4'd4;
  localparam logic [3:0] HEX_DIGITS      = 4'd2;
  localparam logic [3:0] U4_DIGITS       = 4'd4;
  localparam logic [3:0] U8_DIGITS       = 4'd8;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_BSL,
    MODE_OCT,
    MODE_HEX,
    MODE_U4,
    MODE_U8
  } scan_mode_t;

  typedef enum logic [1:0] {
    PK_NONE,
    PK_BYTE,
    PK_PAIR,
    PK_UTF
  } piece_kind_t;

  typedef struct packed {
    piece_kind_t kind;
    logic [31:0] value;
  } piece_t;

  typedef struct packed {
    piece_t p0;
    piece_t p1;
    piece_t p2;
    logic   eot;
    logic   halted;
  } job_t;

  localparam piece_t PIECE_NONE = '{kind: PK_NONE, value: 32'd0};

  function automatic piece_t byte_piece(input logic [7:0] b);
    piece_t p;
    p.kind  = PK_BYTE;
    p.value = {24'd0, b};
    return p;
  endfunction

  function automatic piece_t pair_piece(input logic [7:0] b1, input logic [7:0] b2);
    piece_t p;
    p.kind  = PK_PAIR;
    p.value = {16'd0, b1, b2};
    return p;
  endfunction

  function automatic piece_t utf_piece(input logic [31:0] cp);
    piece_t p;
    if (cp > CP_MAX) begin
      p = PIECE_NONE;
    end else if (cp <= CP_ASCII) begin
      p = byte_piece(cp[7:0]);
    end else begin
      p.kind  = PK_UTF;
      p.value = cp;
    end
    return p;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {["0":"9"], ["a":"f"], ["A":"F"]});
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c inside {["0":"9"]}) begin
      v = c - "0";
    end else if (c inside {["a":"f"]}) begin
      v = c - "a" + 8'd10;
    end else begin
      v = c - "A" + 8'd10;
    end
    return v[3:0];
  endfunction

  // what a pending escape stands for when it ends
  function automatic piece_t finish_piece(input scan_mode_t mode, input logic [31:0] acc,
                                          input logic [3:0] cnt);
    piece_t p;
    case (mode)
      MODE_BSL: p = byte_piece(CH_BSLASH);
      MODE_OCT: p = byte_piece(acc[7:0]);
      MODE_HEX: p = (cnt == 4'd0) ? pair_piece(CH_BSLASH, "x") : byte_piece(acc[7:0]);
      MODE_U4:  p = (cnt == 4'd0) ? pair_piece(CH_BSLASH, "u") : utf_piece(acc);
      MODE_U8:  p = (cnt == 4'd0) ? pair_piece(CH_BSLASH, "U") : utf_piece(acc);
      default:  p = PIECE_NONE;
    endcase
    return p;
  endfunction

  function automatic logic [2:0] utf8_len(input logic [31:0] cp);
    logic [2:0] n;
    if (cp <= 32'h0000_07FF) begin
      n = 3'd2;
    end else if (cp <= 32'h0000_FFFF) begin
      n = 3'd3;
    end else if (cp <= 32'h001F_FFFF) begin
      n = 3'd4;
    end else if (cp <= 32'h03FF_FFFF) begin
      n = 3'd5;
    end else begin
      n = 3'd6;
    end
    return n;
  endfunction

  function automatic logic [7:0] utf8_lead(input logic [2:0] n);
    logic [7:0] l;
    case (n)
      3'd2:    l = 8'hC0;
      3'd3:    l = 8'hE0;
      3'd4:    l = 8'hF0;
      3'd5:    l = 8'hF8;
      3'd6:    l = 8'hFC;
      default: l = 8'h00;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [31:0] cp, input logic [2:0] n,
                                           input logic [2:0] idx);
    logic [2:0]  sh;
    logic [31:0] part;
    sh = (idx == 3'd0) ? n - 3'd1 : n - 3'd1 - idx;
    case (sh)
      3'd0:    part = cp;
      3'd1:    part = cp >> 6;
      3'd2:    part = cp >> 12;
      3'd3:    part = cp >> 18;
      3'd4:    part = cp >> 24;
      3'd5:    part = cp >> 30;
      default: part = cp;
    endcase
    if (idx == 3'd0) begin
      return utf8_lead(n) | part[7:0];
    end
    return 8'h80 | {2'b00, part[5:0]};
  endfunction

  function automatic logic [2:0] piece_len(input piece_t p);
    logic [2:0] n;
    case (p.kind)
      PK_NONE: n = 3'd0;
      PK_BYTE: n = 3'd1;
      PK_PAIR: n = 3'd2;
      PK_UTF:  n = utf8_len(p.value);
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] piece_byte(input piece_t p, input logic [2:0] n,
                                            input logic [2:0] idx);
    logic [7:0] b;
    case (p.kind)
      PK_BYTE: b = p.value[7:0];
      PK_PAIR: b = (idx == 3'd0) ? p.value[15:8] : p.value[7:0];
      PK_UTF:  b = utf8_byte(p.value, n, idx);
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[rtl/bed_if.sv]
interface bed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface bed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       run_last;
  logic       halted;
  logic       text_done;

  modport source (output valid, output out_byte, output has_byte, output run_last,
                  output halted, output text_done, input ready);
  modport sink   (input valid, input out_byte, input has_byte, input run_last,
                  input halted, input text_done, output ready);
endinterface

interface bed_cfg_if;
  logic valid;
  logic ready;
  logic b_mode;

  modport source (output valid, output b_mode, input ready);
  modport sink   (input valid, input b_mode, output ready);
endinterface

[rtl/backslash_escape_decoder_unit.sv]
// An accepted item's job is registered in the job queue, then each result in the output
// register. Throughput: one item per cycle while each item yields at most one result and
// nothing stalls; an item that expands to n bytes holds the output stage, one result per
// cycle. A four-entry job queue between decoder and byte emitter absorbs such bursts.
// Reset (rst, synchronous): idle scan state, halt cleared, b_mode 0, queue empty.
module backslash_escape_decoder_unit #(
  parameter int QUEUE_DEPTH = bed_pkg::BED_QUEUE_DEPTH
) (
  input logic        clk,
  input logic        rst,
  bed_in_if.sink     text_in,
  bed_cfg_if.sink    cfg,
  bed_out_if.source  text_out
);
  import bed_pkg::*;

  logic push, full, q_valid, pop;
  job_t job_in, job_out;

  bed_front u_front (
    .clk     (clk),
    .rst     (rst),
    .text_in (text_in),
    .cfg     (cfg),
    .q_full  (full),
    .push    (push),
    .job     (job_in)
  );

  bed_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .job_in  (job_in),
    .full    (full),
    .q_valid (q_valid),
    .job_out (job_out),
    .pop     (pop)
  );

  bed_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .job      (job_out),
    .pop      (pop),
    .text_out (text_out)
  );

endmodule

[rtl/bed_front.sv]
module bed_front (
  input  logic          clk,
  input  logic          rst,
  bed_in_if.sink        text_in,
  bed_cfg_if.sink       cfg,
  input  logic          q_full,
  output logic          push,
  output bed_pkg::job_t job
);
  import bed_pkg::*;

  scan_mode_t  mode, mode_next;
  logic [31:0] acc, acc_next;
  logic [3:0]  cnt, cnt_next;
  logic        olong, olong_next;
  logic        halt, halt_next;
  logic        b_mode;

  logic [7:0]  c;
  logic        eot;
  logic        accept;
  logic        is_oct;
  logic        digit_take;
  logic        at_limit;
  logic [31:0] d_acc;
  logic [3:0]  d_cnt;
  logic [3:0]  d_lim;
  piece_t      p0, p1, p2;

  assign c             = text_in.in_byte;
  assign eot           = text_in.end_of_text;
  assign text_in.ready = !q_full;
  assign accept        = text_in.valid && text_in.ready;
  assign cfg.ready     = 1'b1;

  always_comb begin
    is_oct     = c inside {["0":"7"]};
    digit_take = 1'b0;
    d_acc      = acc;
    d_lim      = OCT_DIGITS;
    case (mode)
      MODE_OCT: begin
        digit_take = is_oct;
        d_acc      = {20'd0, acc[8:0], c[2:0]};
        d_lim      = olong ? OCT_LONG_DIGITS : OCT_DIGITS;
      end
      MODE_HEX: begin
        digit_take = is_hex(c);
        d_acc      = {acc[27:0], hex_val(c)};
        d_lim      = HEX_DIGITS;
      end
      MODE_U4: begin
        digit_take = is_hex(c);
        d_acc      = {acc[27:0], hex_val(c)};
        d_lim      = U4_DIGITS;
      end
      MODE_U8: begin
        digit_take = is_hex(c);
        d_acc      = {acc[27:0], hex_val(c)};
        d_lim      = U8_DIGITS;
      end
      default: ;
    endcase
    d_cnt    = cnt + 4'd1;
    at_limit = d_cnt >= d_lim;
  end

  always_comb begin
    mode_next  = mode;
    acc_next   = acc;
    cnt_next   = cnt;
    olong_next = olong;
    halt_next  = halt;
    p0         = PIECE_NONE;
    p1         = PIECE_NONE;
    p2         = PIECE_NONE;
    if (!halt) begin
      if (digit_take) begin
        if (at_limit) begin
          p0         = finish_piece(mode, d_acc, d_cnt);
          mode_next  = MODE_IDLE;
          acc_next   = '0;
          cnt_next   = '0;
          olong_next = 1'b0;
        end else begin
          acc_next = d_acc;
          cnt_next = d_cnt;
        end
      end else if (mode == MODE_BSL) begin
        mode_next = MODE_IDLE;
        acc_next  = '0;
        cnt_next  = '0;
        case (c)
          "a":       p1 = byte_piece(CH_BEL);
          "b":       p1 = byte_piece(CH_BS);
          "e", "E":  p1 = byte_piece(CH_ESC);
          "f":       p1 = byte_piece(CH_FF);
          "n":       p1 = byte_piece(CH_LF);
          "r":       p1 = byte_piece(CH_CR);
          "t":       p1 = byte_piece(CH_TAB);
          "v":       p1 = byte_piece(CH_VT);
          CH_BSLASH: p1 = byte_piece(CH_BSLASH);
          "c": begin
            if (b_mode) begin
              halt_next = 1'b1;
            end else begin
              p1 = pair_piece(CH_BSLASH, c);
            end
          end
          "x":       mode_next = MODE_HEX;
          "u":       mode_next = MODE_U4;
          "U":       mode_next = MODE_U8;
          default: begin
            if (is_oct) begin
              olong_next = b_mode && (c == "0");
              acc_next   = {29'd0, c[2:0]};
              cnt_next   = 4'd1;
              mode_next  = MODE_OCT;
            end else begin
              p1 = pair_piece(CH_BSLASH, c);
            end
          end
        endcase
      end else begin
        p0         = finish_piece(mode, acc, cnt);
        mode_next  = MODE_IDLE;
        acc_next   = '0;
        cnt_next   = '0;
        olong_next = 1'b0;
        if (c == CH_BSLASH) begin
          mode_next = MODE_BSL;
        end else begin
          p1 = byte_piece(c);
        end
      end
      if (eot && !halt_next) begin
        p2         = finish_piece(mode_next, acc_next, cnt_next);
        mode_next  = MODE_IDLE;
        acc_next   = '0;
        cnt_next   = '0;
        olong_next = 1'b0;
      end
    end
  end

  assign push = accept && (eot || p0.kind != PK_NONE || p1.kind != PK_NONE
                           || p2.kind != PK_NONE);

  always_comb begin
    job.p0     = p0;
    job.p1     = p1;
    job.p2     = p2;
    job.eot    = eot;
    job.halted = halt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      acc    <= '0;
      cnt    <= '0;
      olong  <= 1'b0;
      halt   <= 1'b0;
      b_mode <= 1'b0;
    end else begin
      if (accept) begin
        mode  <= mode_next;
        acc   <= acc_next;
        cnt   <= cnt_next;
        olong <= olong_next;
        halt  <= halt_next;
      end
      if (cfg.valid && cfg.ready) begin
        b_mode <= cfg.b_mode;
      end
    end
  end

endmodule

[rtl/bed_queue.sv]
module bed_queue #(
  parameter int DEPTH = bed_pkg::BED_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bed_pkg::job_t job_in,
  output logic          full,
  output logic          q_valid,
  output bed_pkg::job_t job_out,
  input  logic          pop
);
  import bed_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr, rd;
  logic [CW-1:0] count;

  assign full    = count == CW'(DEPTH);
  assign q_valid = count != '0;
  assign job_out = mem[rd];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr <= (wr == PW'(DEPTH - 1)) ? '0 : wr + PW'(1);
      end
      if (pop) begin
        rd <= (rd == PW'(DEPTH - 1)) ? '0 : rd + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[rtl/bed_back.sv]
module bed_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  bed_pkg::job_t job,
  output logic          pop,
  bed_out_if.source     text_out
);
  import bed_pkg::*;

  piece_t     pc [3];
  logic [2:0] len [3];
  logic [1:0] pidx, cur;
  logic [2:0] bidx;
  logic       any, later, piece_last, last, load, emit;
  logic [7:0] byte_val;

  logic       o_valid;
  logic [7:0] o_byte;
  logic       o_has, o_last, o_halted, o_done;

  assign pc[0] = job.p0;
  assign pc[1] = job.p1;
  assign pc[2] = job.p2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      len[i] = piece_len(pc[i]);
    end
  end

  always_comb begin
    if (pidx == 2'd0 && len[0] != 3'd0) begin
      cur = 2'd0;
    end else if (pidx <= 2'd1 && len[1] != 3'd0) begin
      cur = 2'd1;
    end else begin
      cur = 2'd2;
    end
    case (cur)
      2'd0:    later = len[1] != 3'd0 || len[2] != 3'd0;
      2'd1:    later = len[2] != 3'd0;
      default: later = 1'b0;
    endcase
    any        = (len[0] | len[1] | len[2]) != 3'd0;
    piece_last = bidx == len[cur] - 3'd1;
    last       = !any || (piece_last && !later);
    byte_val   = piece_byte(pc[cur], len[cur], bidx);
  end

  assign load = !o_valid || text_out.ready;
  assign emit = q_valid && load;
  assign pop  = emit && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      pidx    <= '0;
      bidx    <= '0;
    end else begin
      if (emit) begin
        o_valid <= 1'b1;
        if (last) begin
          pidx <= '0;
          bidx <= '0;
        end else if (piece_last) begin
          pidx <= cur + 2'd1;
          bidx <= '0;
        end else begin
          bidx <= bidx + 3'd1;
        end
      end else if (text_out.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_byte   <= byte_val;
      o_has    <= any;
      o_last   <= last;
      o_halted <= job.halted;
      o_done   <= job.eot && last;
    end
  end

  assign text_out.valid     = o_valid;
  assign text_out.out_byte  = o_byte;
  assign text_out.has_byte  = o_has;
  assign text_out.run_last  = o_last;
  assign text_out.halted    = o_halted;
  assign text_out.text_done = o_done;

endmodule

[rtl/bed_checker.sv]
`include "assert_macros.svh"

module bed_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       has_byte,
  input logic       run_last,
  input logic       halted,
  input logic       text_done
);

  `BED_ASSERT(a_out_hold, clk, rst,
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last),
    "stalled item changed")
  `BED_ASSERT_IMPL(a_empty_form, clk, rst, out_valid && !has_byte,
    out_byte == 8'h00 && run_last && text_done, "empty item malformed")
  `BED_ASSERT_IMPL(a_done_last, clk, rst, out_valid && text_done, run_last,
    "text_done without run_last")
  `BED_ASSERT_IMPL(a_halt_quiet, clk, rst, out_valid && halted, !has_byte,
    "byte emitted after halt")

endmodule

bind backslash_escape_decoder_unit bed_checker u_bed_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (text_out.valid),
  .out_ready (text_out.ready),
  .out_byte  (text_out.out_byte),
  .has_byte  (text_out.has_byte),
  .run_last  (text_out.run_last),
  .halted    (text_out.halted),
  .text_done (text_out.text_done)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import bed_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_PRINTS     = 30;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       eot;
  } text_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       halted;
    logic       text_done;
  } dec_rec_t;

  typedef enum int {
    RX_OPEN,
    RX_RANDOM,
    RX_PERIODIC,
    RX_LONG_STALL
  } rx_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bed_in_if  text_in ();
  bed_cfg_if cfg ();
  bed_out_if text_out ();

  backslash_escape_decoder_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .text_in  (text_in),
    .cfg      (cfg),
    .text_out (text_out)
  );

  always #4 clk = ~clk;

  text_item_t text_q[$];
  dec_rec_t   decoded_q[$];

  // decoder shadow state
  scan_mode_t  esc_mode = MODE_IDLE;
  logic [31:0] esc_acc = '0;
  logic [3:0]  esc_cnt = '0;
  logic        esc_long = 1'b0;
  logic        halt_seen = 1'b0;
  logic        mode_b = 1'b0;
  logic [7:0]  emit_buf[7];
  int          emit_n;

  int err_count = 0;
  int accepted_cnt = 0;
  int queued_cnt = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;

  logic       in_fire = 1'b0;
  logic       drain_hold = 1'b0;
  int         gap_left = 0;
  int         burst_left = 1;
  text_item_t drv_item;

  int        rx_tick = 0;
  int        rx_period = 3;
  rx_style_t rx_style = RX_OPEN;

  logic       gen_bmode = 1'b0;
  logic       halt_ok = 1'b0;
  logic [7:0] last_push = 8'h00;

  function automatic logic hex_digit_ok(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_digit_val(input logic [7:0] c);
    logic [7:0] d;
    if (c <= "9") begin
      d = c - "0";
    end else if (c >= "a") begin
      d = c - "a" + 8'd10;
    end else begin
      d = c - "A" + 8'd10;
    end
    return d[3:0];
  endfunction

  task put_byte(input logic [7:0] b);
    if (!halt_seen && emit_n < 7) begin
      emit_buf[emit_n] = b;
      emit_n++;
    end
  endtask

  task put_code_point(input logic [31:0] cp);
    int          nb;
    int          k;
    logic [7:0]  lead;
    logic [31:0] sh;
    if (cp > CP_MAX) return;
    if (cp <= CP_ASCII) begin
      put_byte(cp[7:0]);
      return;
    end
    if (cp <= 32'h0000_07FF) begin
      nb = 2;
      lead = 8'hC0;
    end else if (cp <= 32'h0000_FFFF) begin
      nb = 3;
      lead = 8'hE0;
    end else if (cp <= 32'h001F_FFFF) begin
      nb = 4;
      lead = 8'hF0;
    end else if (cp <= 32'h03FF_FFFF) begin
      nb = 5;
      lead = 8'hF8;
    end else begin
      nb = 6;
      lead = 8'hFC;
    end
    sh = cp >> (6 * (nb - 1));
    put_byte(lead | sh[7:0]);
    for (k = nb - 2; k >= 0; k--) begin
      sh = cp >> (6 * k);
      put_byte({2'b10, sh[5:0]});
    end
  endtask

  task flush_escape();
    case (esc_mode)
      MODE_BSL: put_byte(CH_BSLASH);
      MODE_OCT: put_byte(esc_acc[7:0]);
      MODE_HEX: begin
        if (esc_cnt == 4'd0) begin
          put_byte(CH_BSLASH);
          put_byte("x");
        end else begin
          put_byte(esc_acc[7:0]);
        end
      end
      MODE_U4, MODE_U8: begin
        if (esc_cnt == 4'd0) begin
          put_byte(CH_BSLASH);
          put_byte(esc_mode == MODE_U4 ? "u" : "U");
        end else begin
          put_code_point(esc_acc);
        end
      end
      default: ;
    endcase
    esc_mode = MODE_IDLE;
    esc_acc = '0;
    esc_cnt = '0;
    esc_long = 1'b0;
  endtask

  task after_backslash(input logic [7:0] c);
    esc_mode = MODE_IDLE;
    esc_acc = '0;
    esc_cnt = '0;
    case (c)
      "a":      put_byte(CH_BEL);
      "b":      put_byte(CH_BS);
      "e", "E": put_byte(CH_ESC);
      "f":      put_byte(CH_FF);
      "n":      put_byte(CH_LF);
      "r":      put_byte(CH_CR);
      "t":      put_byte(CH_TAB);
      "v":      put_byte(CH_VT);
      CH_BSLASH: put_byte(CH_BSLASH);
      "c": begin
        if (mode_b) begin
          halt_seen = 1'b1;
        end else begin
          put_byte(CH_BSLASH);
          put_byte("c");
        end
      end
      "x": esc_mode = MODE_HEX;
      "u": esc_mode = MODE_U4;
      "U": esc_mode = MODE_U8;
      default: begin
        if (c >= "0" && c <= "7") begin
          esc_long = mode_b && (c == "0");
          esc_acc = {29'd0, c[2:0]};
          esc_cnt = 4'd1;
          esc_mode = MODE_OCT;
        end else begin
          put_byte(CH_BSLASH);
          put_byte(c);
        end
      end
    endcase
  endtask

  task feed_byte(input logic [7:0] c);
    logic [3:0] dig_max;
    if (halt_seen) return;
    case (esc_mode)
      MODE_BSL: begin
        after_backslash(c);
        return;
      end
      MODE_OCT: begin
        dig_max = esc_long ? OCT_LONG_DIGITS : OCT_DIGITS;
        if (c >= "0" && c <= "7" && esc_cnt < dig_max) begin
          esc_acc = ((esc_acc << 3) | {29'd0, c[2:0]}) & 32'h0000_0FFF;
          esc_cnt++;
          if (esc_cnt >= dig_max) flush_escape();
          return;
        end
      end
      MODE_HEX, MODE_U4, MODE_U8: begin
        dig_max = (esc_mode == MODE_HEX) ? HEX_DIGITS :
                  (esc_mode == MODE_U4) ? U4_DIGITS : U8_DIGITS;
        if (hex_digit_ok(c) && esc_cnt < dig_max) begin
          esc_acc = (esc_acc << 4) | {28'd0, hex_digit_val(c)};
          esc_cnt++;
          if (esc_cnt >= dig_max) flush_escape();
          return;
        end
      end
      default: ;
    endcase
    flush_escape();
    if (c == CH_BSLASH) begin
      esc_mode = MODE_BSL;
    end else begin
      put_byte(c);
    end
  endtask

  task decode_step(input logic [7:0] c, input logic eot);
    dec_rec_t r;
    int       k;
    emit_n = 0;
    feed_byte(c);
    if (eot && !halt_seen) flush_escape();
    for (k = 0; k < emit_n; k++) begin
      r.out_byte  = emit_buf[k];
      r.has_byte  = 1'b1;
      r.run_last  = (k == emit_n - 1);
      r.halted    = halt_seen;
      r.text_done = eot && (k == emit_n - 1);
      decoded_q.push_back(r);
    end
    if (eot && emit_n == 0) begin
      r = '{out_byte: 8'h00, has_byte: 1'b0, run_last: 1'b1, halted: halt_seen,
            text_done: 1'b1};
      decoded_q.push_back(r);
    end
  endtask

  task report_miss(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task check_result();
    dec_rec_t got;
    dec_rec_t want;
    got = '{out_byte: text_out.out_byte, has_byte: text_out.has_byte,
            run_last: text_out.run_last, halted: text_out.halted,
            text_done: text_out.text_done};
    if (decoded_q.size() == 0) begin
      report_miss($sformatf("unexpected result byte %02h", got.out_byte));
      return;
    end
    want = decoded_q.pop_front();
    results_seen++;
    if (got !== want) begin
      report_miss($sformatf("byte/has/last/halt/done got %02h/%b/%b/%b/%b want %02h/%b/%b/%b/%b",
                            got.out_byte, got.has_byte, got.run_last, got.halted,
                            got.text_done, want.out_byte, want.has_byte, want.run_last,
                            want.halted, want.text_done));
    end
  endtask

  // predict on accept, check results, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (text_in.valid && text_in.ready) begin
        decode_step(text_in.in_byte, text_in.end_of_text);
        accepted_cnt++;
        in_fire = 1'b1;
      end
      if (text_out.valid && text_out.ready) check_result();
      if ((text_in.valid && text_in.ready) || (text_out.valid && text_out.ready) ||
          (cfg.valid && cfg.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // sender: bursts, gaps and an occasional pause until all results are back
  always @(negedge clk) begin
    if (!rst && !(text_in.valid && !in_fire)) begin
      in_fire = 1'b0;
      if (drain_hold && decoded_q.size() != 0) begin
        text_in.valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        text_in.valid <= 1'b0;
      end else if (text_q.size() == 0) begin
        text_in.valid <= 1'b0;
      end else begin
        drain_hold = 1'b0;
        drv_item = text_q.pop_front();
        text_in.valid <= 1'b1;
        text_in.in_byte <= drv_item.in_byte;
        text_in.end_of_text <= drv_item.eot;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          if ($urandom_range(0, 15) == 0) drain_hold = 1'b1;
        end
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick >= 48) begin
      rx_tick = 0;
      rx_style = rx_style_t'($urandom_range(0, 3));
      rx_period = $urandom_range(2, 6);
    end
    case (rx_style)
      RX_OPEN:     text_out.ready <= 1'b1;
      RX_RANDOM:   text_out.ready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: text_out.ready <= ((rx_tick % rx_period) != 0);
      default:     text_out.ready <= ((rx_tick % 16) >= 5);
    endcase
  end

  task push_item(input logic [7:0] b, input logic e);
    text_item_t it;
    // keep backslash-c out of b mode text until the halt is wanted
    if (gen_bmode && !halt_ok && last_push == CH_BSLASH && b == "c") b = "d";
    it.in_byte = b;
    it.eot = e;
    text_q.push_back(it);
    queued_cnt++;
    last_push = b;
  endtask

  task push_text(input string s, input logic eot_last);
    int i;
    for (i = 0; i < s.len(); i++) push_item(s[i], eot_last && (i == s.len() - 1));
  endtask

  task gen_token();
    string      hexset;
    string      simple;
    int         sel;
    int         nd;
    int         i;
    logic       e;
    logic [7:0] b;
    hexset = "0123456789abcdefABCDEF";
    simple = "abeEfnrtv\\c";
    e = ($urandom_range(0, 11) == 0);
    sel = $urandom_range(0, 15);
    case (sel)
      0, 1, 2: begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_BSLASH) b = "/";
        push_item(b, e);
      end
      3: begin
        nd = $urandom_range(1, 4);
        for (i = 0; i < nd; i++) push_item(8'($urandom_range(0, 255)), e && (i == nd - 1));
      end
      4, 5: begin
        push_item(CH_BSLASH, 1'b0);
        push_item(simple[$urandom_range(0, 10)], e);
      end
      6, 7: begin
        push_item(CH_BSLASH, 1'b0);
        nd = $urandom_range(0, 4);
        b = ($urandom_range(0, 1) == 0) ? "0" : 8'("0" + $urandom_range(0, 7));
        push_item(b, e && (nd == 0));
        for (i = 0; i < nd; i++) begin
          push_item(8'("0" + $urandom_range(0, 7)), e && (i == nd - 1));
        end
      end
      8, 9, 10, 11, 12: begin
        push_item(CH_BSLASH, 1'b0);
        if (sel == 8) begin
          b = "x";
          nd = $urandom_range(0, 3);
        end else if (sel < 11) begin
          b = "u";
          nd = $urandom_range(0, 5);
        end else begin
          b = "U";
          nd = $urandom_range(0, 9);
        end
        push_item(b, e && (nd == 0));
        for (i = 0; i < nd; i++) push_item(hexset[$urandom_range(0, 21)], e && (i == nd - 1));
      end
      13: begin
        push_item(CH_BSLASH, 1'b0);
        push_item(8'($urandom_range(0, 255)), e);
      end
      14: push_item(CH_BSLASH, 1'b1);
      default: push_item(8'($urandom_range(0, 255)), 1'b1);
    endcase
  endtask

  task gen_phase(input int n_items);
    int start;
    start = queued_cnt;
    while (queued_cnt - start < n_items) gen_token();
  endtask

  task write_mode(input logic v);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.b_mode <= v;
    do @(posedge clk); while (!cfg.ready);
    mode_b = v;
    gen_bmode = v;
    cfg_writes++;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task wait_drained();
    do @(negedge clk); while (accepted_cnt != queued_cnt || decoded_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic rand_modes[6];
    int   p;
    int   i;
    rand_modes = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    text_in.valid = 1'b0;
    text_in.in_byte = 8'h00;
    text_in.end_of_text = 1'b0;
    cfg.valid = 1'b0;
    cfg.b_mode = 1'b0;
    text_out.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_mode(1'b0);
    @(posedge clk);
    push_text("\\c", 1'b0);
    push_text("\\q", 1'b0);
    push_text("\\xz", 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_text("\\777", 1'b0);
    push_text("\\U", 1'b1);
    push_text("\\", 1'b1);
    push_text("\\0", 1'b0);
    wait_drained();

    // octal digit limit stays short across the mode change
    write_mode(1'b1);
    @(posedge clk);
    push_text("17", 1'b0);
    push_text("\\0123", 1'b0);
    push_text("\\u4", 1'b1);
    wait_drained();

    for (p = 0; p < 6; p++) begin
      write_mode(rand_modes[p]);
      @(posedge clk);
      gen_phase(40);
      wait_drained();
    end

    write_mode(1'b1);
    @(posedge clk);
    gen_phase(10);
    push_item(8'h20, 1'b1);
    halt_ok = 1'b1;
    push_text("\\c", 1'b0);
    for (i = 0; i < 8; i++) push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    push_item(8'($urandom_range(0, 255)), 1'b1);
    wait_drained();
    repeat (20) @(negedge clk);

    $display("%0d text bytes accepted, %0d decoded bytes checked, %0d b_mode writes",
             accepted_cnt, results_seen, cfg_writes);
    $display("escapes under both b_mode settings, output halt reached: %0b", halt_seen);
    if (err_count == 0 && decoded_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
